/* src/gwag_pkg.sv */
// Shared types and constants for the grid warp address generator.
package gwag_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned PosW     = 12;
  localparam int unsigned CellW    = 11;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 2;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_GRID_LOG     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CellW-1:0] cell_col;
    logic [CellW-1:0] cell_row;
    logic [PosW-1:0]  ul_x;
    logic [PosW-1:0]  ul_y;
    logic [PosW-1:0]  ur_x;
    logic [PosW-1:0]  ur_y;
    logic [PosW-1:0]  ll_x;
    logic [PosW-1:0]  ll_y;
    logic [PosW-1:0]  lr_x;
    logic [PosW-1:0]  lr_y;
  } in_t;

  typedef struct packed {
    logic [PosW-1:0] src_x;
    logic [PosW-1:0] src_y;
    logic [PosW-1:0] dst_x;
    logic [PosW-1:0] dst_y;
    logic            cell_done;
  } out_t;

  // Cell as held by the row walker: left/right edge points advance per row.
  typedef struct packed {
    coord_t          lx;
    coord_t          ly;
    coord_t          rx;
    coord_t          ry;
    coord_t          lstep_x;
    coord_t          lstep_y;
    coord_t          rstep_x;
    coord_t          rstep_y;
    logic [PosW-1:0] base_x;
    logic [PosW-1:0] base_y;
  } cell_t;

  typedef struct packed {
    coord_t          px;
    coord_t          py;
    coord_t          sx;
    coord_t          sy;
    logic [PosW-1:0] base_x;
    logic [PosW-1:0] dst_y;
    logic            last_row;
  } row_t;

  typedef struct packed {
    coord_t          px;
    coord_t          py;
    logic [PosW-1:0] dst_x;
    logic [PosW-1:0] dst_y;
    logic            done;
  } pix_t;

endpackage

/* src/gwag_setup.sv */
// Input stage: frame fit check, edge steps and destination base per cell.
module gwag_setup import gwag_pkg::*; #(
  parameter int unsigned LgW  = 2,
  parameter int unsigned DimW = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [LgW-1:0]  lg_i,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_beat_i,
  output logic            cell_valid_o,
  input  logic            cell_ready_i,
  output cell_t           cell_o
);

  localparam int unsigned FitW = CellW + 2**LgW;

  logic [FitW-1:0] span_x, span_y;
  logic            fits;
  cell_t           cell_d, cell_q;
  logic            cell_valid_q;

  assign span_x = (FitW'(in_beat_i.cell_col) + FitW'(1)) << lg_i;
  assign span_y = (FitW'(in_beat_i.cell_row) + FitW'(1)) << lg_i;
  // partial cells at the frame edge produce nothing
  assign fits = (32'(span_x) <= 32'(width_i)) && (32'(span_y) <= 32'(height_i));

  always_comb begin
    cell_d.lx      = coord_t'(in_beat_i.ul_x);
    cell_d.ly      = coord_t'(in_beat_i.ul_y);
    cell_d.rx      = coord_t'(in_beat_i.ur_x);
    cell_d.ry      = coord_t'(in_beat_i.ur_y);
    cell_d.lstep_x = (coord_t'(in_beat_i.ll_x) - coord_t'(in_beat_i.ul_x)) >>> lg_i;
    cell_d.lstep_y = (coord_t'(in_beat_i.ll_y) - coord_t'(in_beat_i.ul_y)) >>> lg_i;
    cell_d.rstep_x = (coord_t'(in_beat_i.lr_x) - coord_t'(in_beat_i.ur_x)) >>> lg_i;
    cell_d.rstep_y = (coord_t'(in_beat_i.lr_y) - coord_t'(in_beat_i.ur_y)) >>> lg_i;
    cell_d.base_x  = PosW'(32'(in_beat_i.cell_col) << lg_i);
    cell_d.base_y  = PosW'(32'(in_beat_i.cell_row) << lg_i);
  end

  assign in_ready_o = !cell_valid_q || cell_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      cell_valid_q <= in_valid_i && fits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_valid_o = cell_valid_q;
  assign cell_o       = cell_q;

  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid_q && !cell_ready_i |=> cell_valid_q && $stable(cell_q))
    else $error("setup stage dropped or changed a stalled cell");

endmodule

/* src/gwag_row_walk.sv */
// Row walker: steps the edge points down the cell, one row beat per cycle while row_ready_i is high.
module gwag_row_walk import gwag_pkg::*; #(
  parameter int unsigned LgW  = 2,
  parameter int unsigned CntW = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [LgW-1:0] lg_i,
  input  logic           cell_valid_i,
  output logic           cell_ready_o,
  input  cell_t          cell_i,
  output logic           row_valid_o,
  input  logic           row_ready_i,
  output row_t           row_o
);

  cell_t            cur_q;
  logic             busy_q;
  logic [CntW-1:0]  row_q;
  logic [CntW-1:0]  cnt_max;
  logic             last_row, fire, load_ok;

  assign cnt_max  = CntW'((32'd1 << lg_i) - 32'd1);
  assign last_row = (row_q == cnt_max);
  assign fire     = busy_q && row_ready_i;
  assign load_ok  = !busy_q || (fire && last_row);

  assign cell_ready_o = load_ok;
  assign row_valid_o  = busy_q;

  always_comb begin
    row_o.px       = cur_q.lx;
    row_o.py       = cur_q.ly;
    row_o.sx       = (cur_q.rx - cur_q.lx) >>> lg_i;
    row_o.sy       = (cur_q.ry - cur_q.ly) >>> lg_i;
    row_o.base_x   = cur_q.base_x;
    row_o.dst_y    = cur_q.base_y + PosW'(row_q);
    row_o.last_row = last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (load_ok) begin
      busy_q <= cell_valid_i;
      row_q  <= '0;
    end else if (fire) begin
      row_q  <= row_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && cell_valid_i) begin
      cur_q <= cell_i;
    end else if (fire) begin
      cur_q.lx <= cur_q.lx + cur_q.lstep_x;
      cur_q.ly <= cur_q.ly + cur_q.lstep_y;
      cur_q.rx <= cur_q.rx + cur_q.rstep_x;
      cur_q.ry <= cur_q.ry + cur_q.rstep_y;
    end
  end

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_row |=> !busy_q || row_q == '0)
    else $error("row counter did not restart after the last row");

endmodule

/* src/gwag_pix_walk.sv */
// Pixel walker: steps across one row, one pixel beat per cycle while pix_ready_i is high.
module gwag_pix_walk import gwag_pkg::*; #(
  parameter int unsigned LgW  = 2,
  parameter int unsigned CntW = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [LgW-1:0] lg_i,
  input  logic           row_valid_i,
  output logic           row_ready_o,
  input  row_t           row_i,
  output logic           pix_valid_o,
  input  logic           pix_ready_i,
  output pix_t           pix_o
);

  row_t             cur_q;
  logic             busy_q;
  logic [CntW-1:0]  col_q;
  logic [CntW-1:0]  cnt_max;
  logic             last_col, fire, load_ok;

  assign cnt_max  = CntW'((32'd1 << lg_i) - 32'd1);
  assign last_col = (col_q == cnt_max);
  assign fire     = busy_q && pix_ready_i;
  assign load_ok  = !busy_q || (fire && last_col);

  assign row_ready_o = load_ok;
  assign pix_valid_o = busy_q;

  always_comb begin
    pix_o.px    = cur_q.px;
    pix_o.py    = cur_q.py;
    pix_o.dst_x = cur_q.base_x + PosW'(col_q);
    pix_o.dst_y = cur_q.dst_y;
    pix_o.done  = cur_q.last_row && last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
    end else if (load_ok) begin
      busy_q <= row_valid_i;
      col_q  <= '0;
    end else if (fire) begin
      col_q  <= col_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && row_valid_i) begin
      cur_q <= row_i;
    end else if (fire) begin
      cur_q.px <= cur_q.px + cur_q.sx;
      cur_q.py <= cur_q.py + cur_q.sy;
    end
  end

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_col |=> !busy_q || col_q == '0)
    else $error("column counter did not restart after the last pixel");

endmodule

/* src/gwag_clamp.sv */
// Output stage: clamps source coordinates to the frame and holds the result beat.
module gwag_clamp import gwag_pkg::*; #(
  parameter int unsigned DimW = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  input  logic            pix_valid_i,
  output logic            pix_ready_o,
  input  pix_t            pix_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_o
);

  localparam int unsigned CmpW = (DimW + 1 > CoordW) ? DimW + 1 : CoordW;

  function automatic logic [PosW-1:0] clamp_coord(coord_t v, logic [DimW-1:0] lim);
    logic signed [CmpW-1:0] v_ext;
    logic signed [CmpW-1:0] top_ext;
    v_ext   = CmpW'(v);
    top_ext = signed'(CmpW'(lim - DimW'(1)));
    if (v_ext[CmpW-1]) begin
      return '0;
    end else if (v_ext > top_ext) begin
      return PosW'(top_ext);
    end else begin
      return PosW'(v_ext);
    end
  endfunction

  out_t out_d, out_q;
  logic out_valid_q;

  always_comb begin
    out_d.src_x     = clamp_coord(pix_i.px, width_i);
    out_d.src_y     = clamp_coord(pix_i.py, height_i);
    out_d.dst_x     = pix_i.dst_x;
    out_d.dst_y     = pix_i.dst_y;
    out_d.cell_done = pix_i.done;
  end

  assign pix_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      out_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* src/grid_warp_address_generator_core.sv */
// Top level of the grid warp address generator: config registers and pipeline.
//
// Usage: each input beat on in_valid_i/in_ready_o carries one grid cell (its
// column and row plus four displaced corner points). The block emits, row by
// row and left to right, one result beat per destination pixel of the cell on
// out_valid_o/out_ready_i: clamped source coordinate, destination pixel and a
// cell_done flag on the cell's final pixel. Cells that do not lie wholly in the
// frame are accepted and produce no beats.
// Pipeline: setup -> row walker -> pixel walker -> clamp/output register.
// The pixel walker emits one result per cycle unless stalled, so a cell yields
// 2^(2*grid_log) results (4 at the reset grid_log of 1, 64 at grid_log 3); the
// next cell is set up while the current one is still walking, so cells follow
// with no gap. Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
// once; the user must make them only while the block is empty; the block itself
// does not enforce this. Reset clears all valid bits and loads frame 640 x 480,
// grid_log 1; no clearing pass is needed.
// A stalled receiver holds the output register; the stall backs up stage by
// stage into in_ready_o without losing or repeating a beat.
module grid_warp_address_generator_core import gwag_pkg::*; #(
  parameter int unsigned MAX_DIM      = 4096,
  parameter int unsigned MAX_GRID_LOG = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_beat_o
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned LgW  = $clog2(MAX_GRID_LOG + 1);
  localparam int unsigned CntW = MAX_GRID_LOG;

  function automatic logic [DimW-1:0] eff_dim(logic [CfgDataW-1:0] d);
    if (d == '0) begin
      return DimW'(1);
    end else if (32'(d) > MAX_DIM) begin
      return DimW'(MAX_DIM);
    end else begin
      return DimW'(d);
    end
  endfunction

  logic [CfgDataW-1:0] frame_width_q, frame_height_q;
  logic [1:0]          grid_log_q;
  logic [LgW-1:0]      lg;
  logic [DimW-1:0]     width, height;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgDataW'(640);
      frame_height_q <= CfgDataW'(480);
      grid_log_q     <= 2'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        CFG_GRID_LOG:     grid_log_q     <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_log_q == '0) begin
      lg = LgW'(1);
    end else if (32'(grid_log_q) > MAX_GRID_LOG) begin
      lg = LgW'(MAX_GRID_LOG);
    end else begin
      lg = LgW'(grid_log_q);
    end
  end

  assign width  = eff_dim(frame_width_q);
  assign height = eff_dim(frame_height_q);

  logic  cell_valid, cell_ready, row_valid, row_ready, pix_valid, pix_ready;
  cell_t cell_beat;
  row_t  row_beat;
  pix_t  pix_beat;

  gwag_setup #(.LgW(LgW), .DimW(DimW)) u_setup (
    .clk_i,
    .rst_ni,
    .lg_i         (lg),
    .width_i      (width),
    .height_i     (height),
    .in_valid_i,
    .in_ready_o,
    .in_beat_i,
    .cell_valid_o (cell_valid),
    .cell_ready_i (cell_ready),
    .cell_o       (cell_beat)
  );

  gwag_row_walk #(.LgW(LgW), .CntW(CntW)) u_row_walk (
    .clk_i,
    .rst_ni,
    .lg_i         (lg),
    .cell_valid_i (cell_valid),
    .cell_ready_o (cell_ready),
    .cell_i       (cell_beat),
    .row_valid_o  (row_valid),
    .row_ready_i  (row_ready),
    .row_o        (row_beat)
  );

  gwag_pix_walk #(.LgW(LgW), .CntW(CntW)) u_pix_walk (
    .clk_i,
    .rst_ni,
    .lg_i        (lg),
    .row_valid_i (row_valid),
    .row_ready_o (row_ready),
    .row_i       (row_beat),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_o       (pix_beat)
  );

  gwag_clamp #(.DimW(DimW)) u_clamp (
    .clk_i,
    .rst_ni,
    .width_i     (width),
    .height_i    (height),
    .pix_valid_i (pix_valid),
    .pix_ready_o (pix_ready),
    .pix_i       (pix_beat),
    .out_valid_o,
    .out_ready_i,
    .out_o       (out_beat_o)
  );

endmodule
